/* sv/tcs_pkg.sv */
package tcs_pkg;

    // Fixed byte codes
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] DELIM_RESET  = 8'd9;

    // Select modes (code 3 behaves as byte mode)
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_CHAR  = 2'd1;
    localparam logic [1:0] MODE_FIELD = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W        = 3;
    localparam int         CFG_DATA_W       = 32;
    localparam logic [2:0] CFG_SELECT_MODE  = 3'd0;
    localparam logic [2:0] CFG_DELIMITER    = 3'd1;
    localparam logic [2:0] CFG_SUPPRESS     = 3'd2;
    localparam logic [2:0] CFG_RANGE_BASE   = 3'd3;

    // Open upper bound of a range
    localparam logic [15:0] RANGE_OPEN = 16'hFFFF;

    typedef struct packed {
        logic [15:0] last;
        logic [15:0] first;
    } range_t;

endpackage

/* sv/tcs_field_mem.sv */
module tcs_field_mem #(
    parameter int DEPTH  = 48,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/tcs_range_match.sv */
module tcs_range_match #(
    parameter int RANGE_SLOTS   = 4,
    parameter int POSITION_BITS = 16
) (
    input  tcs_pkg::range_t [RANGE_SLOTS-1:0] ranges,
    input  logic [POSITION_BITS-1:0]          pos,
    output logic                              hit
);
    import tcs_pkg::*;

    localparam int CMP_W = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    logic [CMP_W-1:0] pos_x;

    assign pos_x = CMP_W'(pos);

    // Slot hits when enabled, at or past first, and at or before last (or open)
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < RANGE_SLOTS; i++) begin
            if ((ranges[i].first != 16'd0) &&
                (pos_x >= CMP_W'(ranges[i].first)) &&
                ((ranges[i].last == RANGE_OPEN) || (pos_x <= CMP_W'(ranges[i].last)))) begin
                hit = 1'b1;
            end
        end
    end

endmodule

/* sv/text_column_selector.sv */
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_in_byte
// m_        out        m_valid / m_ready    m_out_byte, m_run_last, m_field_truncated,
//                                           m_bad_utf8
// cfg_      in         cfg_we (no wait)     cfg_index, cfg_wdata
//
// An item is captured in the input register, then processed from it.
// A field-mode item that replays the buffered first field of N bytes steps through
// one memory read and one output load per byte, then loads a trailing newline or
// delimiter if one is kept; the first-field memory has a single read port.
// Reset (aresetn low at a clock edge) clears the configuration to its defaults and
// the line state; the first-field memory needs no clearing pass.
// A stalled output holds its item in the output register; one further input item
// is captured meanwhile and waits until the output register frees.
module text_column_selector #(
    parameter int RANGE_SLOTS     = 4,
    parameter int FIRST_FIELD_MAX = 48,
    parameter int POSITION_BITS   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_in_byte,
    // result items
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_out_byte,
    output logic                           m_run_last,
    output logic                           m_field_truncated,
    output logic                           m_bad_utf8,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tcs_pkg::*;

    localparam int ADDR_W = $clog2(FIRST_FIELD_MAX);
    localparam int LEN_W  = $clog2(FIRST_FIELD_MAX + 1);

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [LEN_W-1:0]         LEN_MAX = LEN_W'(FIRST_FIELD_MAX);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_TAIL = 2'd3;

    // Configuration
    logic [1:0]                      mode_reg;
    logic [7:0]                      delim_reg;
    logic                            suppress_reg;
    range_t [RANGE_SLOTS-1:0]        range_reg;

    // Input holding register
    logic                            hold_valid_reg;
    logic [7:0]                      hold_byte_reg;

    // Line state
    logic [POSITION_BITS-1:0]        pos_reg, pos_next;
    logic [POSITION_BITS-1:0]        fc_reg, fc_next;
    logic                            dseen_reg, dseen_next;
    logic                            femit_reg, femit_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic [1:0]                      cont_reg, cont_next;
    logic                            csel_reg, csel_next;
    logic                            ovf_reg, ovf_next;

    // Replay sequencer
    logic [1:0]                      state_reg, state_next;
    logic [ADDR_W-1:0]               rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0]                replay_len_reg, replay_len_next;
    logic                            tail_en_reg, tail_en_next;
    logic [7:0]                      tail_byte_reg, tail_byte_next;
    logic                            trunc_hold_reg, trunc_hold_next;

    // Output register
    logic                            m_valid_reg;
    logic [7:0]                      m_byte_reg;
    logic                            m_last_reg;
    logic                            m_trunc_reg;
    logic                            m_bad_reg;

    // Processing nets
    logic                            out_free;
    logic                            do_proc;
    logic                            is_nl;
    logic                            is_delim;
    logic [POSITION_BITS-1:0]        pos_inc;
    logic [POSITION_BITS-1:0]        fc_inc;
    logic [POSITION_BITS-1:0]        match_arg;
    logic                            hit;
    logic                            hit_first;
    logic                            clear_line;
    logic                            rd_last;
    logic                            utf_bad;
    logic [1:0]                      utf_need;

    logic                            out_load;
    logic [7:0]                      out_byte_d;
    logic                            out_last_d;
    logic                            out_trunc_d;
    logic                            out_bad_d;

    logic                            rp_start;
    logic                            rp_tail_en;
    logic [7:0]                      rp_tail_byte;

    logic                            mem_we;
    logic                            mem_re;
    logic [7:0]                      mem_rdata;

    assign out_free = !m_valid_reg || m_ready;
    assign do_proc  = (state_reg == ST_IDLE) && hold_valid_reg && out_free;
    assign s_ready  = !hold_valid_reg;

    assign is_nl    = (hold_byte_reg == NEWLINE_BYTE);
    assign is_delim = !is_nl && (hold_byte_reg == delim_reg);
    assign pos_inc  = (pos_reg != POS_MAX) ? pos_reg + POS_ONE : pos_reg;
    assign fc_inc   = (fc_reg != POS_MAX) ? fc_reg + POS_ONE : fc_reg;

    // Byte and character modes match the position; field mode the field number
    assign match_arg = (mode_reg != MODE_FIELD) ? pos_reg :
                       (is_delim ? fc_inc : fc_reg);

    assign rd_last = ((LEN_W'(rd_idx_reg) + LEN_W'(1)) == replay_len_reg);

    tcs_range_match #(
        .RANGE_SLOTS   (RANGE_SLOTS),
        .POSITION_BITS (POSITION_BITS)
    ) u_match (
        .ranges (range_reg),
        .pos    (match_arg),
        .hit    (hit)
    );

    tcs_range_match #(
        .RANGE_SLOTS   (RANGE_SLOTS),
        .POSITION_BITS (POSITION_BITS)
    ) u_match_first (
        .ranges (range_reg),
        .pos    (POS_ONE),
        .hit    (hit_first)
    );

    tcs_field_mem #(
        .DEPTH (FIRST_FIELD_MAX)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (hold_byte_reg),
        .rd_en   (mem_re),
        .rd_addr (rd_idx_reg),
        .rd_data (mem_rdata)
    );

    // Classify a UTF-8 lead byte
    always_comb begin
        utf_bad  = (cont_reg != 2'd0);
        utf_need = 2'd0;
        if (!hold_byte_reg[7]) begin
            utf_need = 2'd0;
        end else if (hold_byte_reg[7:6] == 2'b10) begin
            utf_bad = 1'b1;
        end else if (hold_byte_reg[7:5] == 3'b110) begin
            utf_need = 2'd1;
        end else if (hold_byte_reg[7:4] == 4'b1110) begin
            utf_need = 2'd2;
        end else if (hold_byte_reg[7:3] == 5'b11110) begin
            utf_need = 2'd3;
        end else begin
            utf_bad = 1'b1;
        end
    end

    // Item processing and replay sequencing
    always_comb begin
        pos_next        = pos_reg;
        fc_next         = fc_reg;
        dseen_next      = dseen_reg;
        femit_next      = femit_reg;
        len_next        = len_reg;
        cont_next       = cont_reg;
        csel_next       = csel_reg;
        ovf_next        = ovf_reg;
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        replay_len_next = replay_len_reg;
        tail_en_next    = tail_en_reg;
        tail_byte_next  = tail_byte_reg;
        trunc_hold_next = trunc_hold_reg;
        clear_line      = 1'b0;
        out_load        = 1'b0;
        out_byte_d      = hold_byte_reg;
        out_last_d      = 1'b1;
        out_trunc_d     = 1'b0;
        out_bad_d       = 1'b0;
        rp_start        = 1'b0;
        rp_tail_en      = 1'b0;
        rp_tail_byte    = NEWLINE_BYTE;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (do_proc) begin
                    case (mode_reg)
                        MODE_FIELD: begin
                            if (is_nl) begin
                                if (!dseen_reg) begin
                                    // undelimited line: replay whole or drop
                                    if (!suppress_reg) begin
                                        rp_start     = 1'b1;
                                        rp_tail_en   = 1'b1;
                                        rp_tail_byte = NEWLINE_BYTE;
                                    end
                                end else begin
                                    out_load    = 1'b1;
                                    out_byte_d  = NEWLINE_BYTE;
                                    out_trunc_d = ovf_reg;
                                end
                                clear_line = 1'b1;
                            end else if (is_delim) begin
                                fc_next = fc_inc;
                                if (!dseen_reg) begin
                                    dseen_next = 1'b1;
                                end
                                if (!dseen_reg && hit_first) begin
                                    // first field kept: replay it, delimiter follows if kept
                                    femit_next   = 1'b1;
                                    rp_start     = 1'b1;
                                    rp_tail_en   = hit;
                                    rp_tail_byte = delim_reg;
                                end else if (hit) begin
                                    femit_next = 1'b1;
                                    if (femit_reg) begin
                                        out_load    = 1'b1;
                                        out_byte_d  = delim_reg;
                                        out_trunc_d = ovf_reg;
                                    end
                                end
                            end else if (!dseen_reg) begin
                                // buffer first field; drop past capacity
                                if (len_reg < LEN_MAX) begin
                                    mem_we   = 1'b1;
                                    len_next = len_reg + LEN_W'(1);
                                end else begin
                                    ovf_next = 1'b1;
                                end
                            end else if (hit) begin
                                out_load    = 1'b1;
                                out_trunc_d = ovf_reg;
                            end
                        end
                        MODE_CHAR: begin
                            if (is_nl) begin
                                out_load   = 1'b1;
                                out_byte_d = NEWLINE_BYTE;
                                out_bad_d  = (cont_reg != 2'd0);
                                clear_line = 1'b1;
                            end else if ((hold_byte_reg[7:6] == 2'b10) && (cont_reg != 2'd0)) begin
                                cont_next = cont_reg - 2'd1;
                                out_load  = csel_reg;
                            end else begin
                                cont_next = utf_need;
                                csel_next = hit;
                                pos_next  = pos_inc;
                                out_load  = hit;
                                out_bad_d = utf_bad;
                            end
                        end
                        default: begin
                            if (is_nl) begin
                                out_load   = 1'b1;
                                out_byte_d = NEWLINE_BYTE;
                                clear_line = 1'b1;
                            end else begin
                                out_load = hit;
                                pos_next = pos_inc;
                            end
                        end
                    endcase

                    if (rp_start) begin
                        trunc_hold_next = ovf_reg;
                        tail_en_next    = rp_tail_en;
                        tail_byte_next  = rp_tail_byte;
                        if (len_reg == LEN_W'(0)) begin
                            // nothing buffered: only the trailing byte, if any
                            out_load    = rp_tail_en;
                            out_byte_d  = rp_tail_byte;
                            out_trunc_d = ovf_reg;
                        end else begin
                            replay_len_next = len_reg;
                            rd_idx_next     = '0;
                            state_next      = ST_READ;
                        end
                    end

                    if (clear_line) begin
                        pos_next   = POS_ONE;
                        fc_next    = POS_ONE;
                        dseen_next = 1'b0;
                        femit_next = 1'b0;
                        len_next   = '0;
                        cont_next  = 2'd0;
                        csel_next  = 1'b0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            ST_READ: begin
                mem_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_byte_d  = mem_rdata;
                    out_last_d  = rd_last && !tail_en_reg;
                    out_trunc_d = trunc_hold_reg;
                    if (rd_last) begin
                        state_next = tail_en_reg ? ST_TAIL : ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + ADDR_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            ST_TAIL: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_byte_d  = tail_byte_reg;
                    out_trunc_d = trunc_hold_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            mode_reg       <= MODE_BYTE;
            delim_reg      <= DELIM_RESET;
            suppress_reg   <= 1'b0;
            range_reg      <= '0;
            pos_reg        <= POS_ONE;
            fc_reg         <= POS_ONE;
            dseen_reg      <= 1'b0;
            femit_reg      <= 1'b0;
            len_reg        <= '0;
            cont_reg       <= 2'd0;
            csel_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            fc_reg    <= fc_next;
            dseen_reg <= dseen_next;
            femit_reg <= femit_next;
            len_reg   <= len_next;
            cont_reg  <= cont_next;
            csel_reg  <= csel_next;
            ovf_reg   <= ovf_next;

            // capture an item when empty, drop it once processed
            if (s_valid && s_ready) begin
                hold_valid_reg <= 1'b1;
            end else if (do_proc) begin
                hold_valid_reg <= 1'b0;
            end

            // hold the result until taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_SELECT_MODE: mode_reg     <= cfg_wdata[1:0];
                    CFG_DELIMITER:   delim_reg    <= cfg_wdata[7:0];
                    CFG_SUPPRESS:    suppress_reg <= cfg_wdata[0];
                    default: begin
                        for (int i = 0; i < RANGE_SLOTS; i++) begin
                            if (cfg_index == CFG_RANGE_BASE + CFG_IDX_W'(i)) begin
                                range_reg[i] <= range_t'(cfg_wdata);
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        replay_len_reg <= replay_len_next;
        tail_en_reg    <= tail_en_next;
        tail_byte_reg  <= tail_byte_next;
        trunc_hold_reg <= trunc_hold_next;
        if (s_valid && s_ready) begin
            hold_byte_reg <= s_in_byte;
        end
        if (out_load) begin
            m_byte_reg  <= out_byte_d;
            m_last_reg  <= out_last_d;
            m_trunc_reg <= out_trunc_d;
            m_bad_reg   <= out_bad_d;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_byte        = m_byte_reg;
    assign m_run_last        = m_last_reg;
    assign m_field_truncated = m_trunc_reg;
    assign m_bad_utf8        = m_bad_reg;

    // The first-field memory is written only while idle and before the first delimiter
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((state_reg == ST_IDLE) && !dseen_reg))
        else $error("first-field write outside the buffering phase");

    // The fill count never passes the buffer capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("first-field length beyond capacity");

    // Replay reads stay inside the buffered length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (LEN_W'(rd_idx_reg) < replay_len_reg))
        else $error("replay index beyond buffered length");

    // A memory read is always followed by its emit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_EMIT))
        else $error("replay read not followed by emit");

    // Reset leaves the sequencer idle with no result pending
    assert property (@(posedge aclk)
        !aresetn |=> ((state_reg == ST_IDLE) && !m_valid_reg && !hold_valid_reg))
        else $error("reset did not clear sequencer and output");

endmodule
